// ===== rtl/core/ploq_pkg.sv =====
// Shared constants, codes and control structs for the price level order queue.
// No dependencies; every file but ploq_if imports this package.
package ploq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PRICE = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic match;
    logic exec;
  } ploq_cmd_t;

  typedef struct packed {
    logic out_free;
  } ploq_sts_t;

endpackage

// ===== rtl/core/ploq_if.sv =====
// Valid/ready channel interfaces for the request, result and configuration words.
// Field widths are fixed; no dependencies.
interface ploq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] order_id;
  logic [31:0] order_price;
  logic [63:0] order_data;
  modport source (output valid, kind, order_id, order_price, order_data, input ready);
  modport sink (input valid, kind, order_id, order_price, order_data, output ready);
endinterface

interface ploq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_data;
  logic [31:0] head_id;
  logic [63:0] head_data;
  logic [6:0]  order_count;
  logic        is_empty;
  modport source (output valid, status, found_data, head_id, head_data, order_count, is_empty,
                  input ready);
  modport sink (input valid, status, found_data, head_id, head_data, order_count, is_empty,
                output ready);
endinterface

interface ploq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/price_level_order_queue_unit.sv =====
// Top level of the price level order queue: joins controller and datapath.
// Depends on ploq_pkg, ploq_if, ploq_ctrl and ploq_dp.
//
//   channel  direction  word
//   in_ch    sink       kind, order_id, order_price, order_data
//   out_ch   source     status, found_data, head_id, head_data, order_count, is_empty
//   cfg_ch   sink       data (level price), always ready
//
// Each request passes through capture, the parallel id compare over all
// entry cells, then the first-match select with shift and result write.
// One request is in flight at a time; the next is accepted once it has executed.
// A result word waiting on out_ch.ready holds the next request in its execute step.
// Synchronous active-low reset empties the queue and clears the level price.
module price_level_order_queue_unit import ploq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ploq_in_if.sink   in_ch,
  ploq_out_if.source out_ch,
  ploq_cfg_if.sink  cfg_ch
);

  ploq_cmd_t cmd;
  ploq_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ploq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ploq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_order_id     (in_ch.order_id),
    .in_order_price  (in_ch.order_price),
    .in_order_data   (in_ch.order_data),
    .cfg_valid       (cfg_ch.valid),
    .cfg_data        (cfg_ch.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_found_data  (out_ch.found_data),
    .out_head_id     (out_ch.head_id),
    .out_head_data   (out_ch.head_data),
    .out_order_count (out_ch.order_count),
    .out_is_empty    (out_ch.is_empty)
  );

endmodule

// ===== rtl/core/ploq_ctrl.sv =====
// Controller state machine: sequences capture, match and execute for each word.
// Depends on ploq_pkg for the command and status structs.
module ploq_ctrl import ploq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ploq_sts_t sts,
  output ploq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ploq_dp.sv =====
// Datapath: order entry cells with per-entry id compare, gap-closing shift,
// level price register and the registered result word. Depends on ploq_pkg.
module ploq_dp import ploq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ploq_cmd_t   cmd,
  output ploq_sts_t   sts,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_order_id,
  input  logic [31:0] in_order_price,
  input  logic [63:0] in_order_data,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_found_data,
  output logic [31:0] out_head_id,
  output logic [63:0] out_head_data,
  output logic [6:0]  out_order_count,
  output logic        out_is_empty
);

  logic [31:0]      level_price_r;
  kind_t            req_kind_r;
  logic [31:0]      req_id_r;
  logic [31:0]      req_price_r;
  logic [63:0]      req_data_r;
  logic [DEPTH-1:0] match_r, match_nxt;
  logic [31:0]      ids_r [DEPTH];
  logic [31:0]      ids_nxt [DEPTH];
  logic [63:0]      data_r [DEPTH];
  logic [63:0]      data_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [63:0]      found_r, found_nxt;
  logic [31:0]      head_id_r;
  logic [63:0]      head_data_r;

  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] shift;
  logic [63:0]      found_sel;
  logic             hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (ids_r[i] == req_id_r) && (CNT_W'(i) < count_r);
    end
    if (req_kind_r == KIND_POP) begin
      match_nxt    = '0;
      match_nxt[0] = (count_r != '0);
    end
  end

  // The lowest set match bit is the order nearest the head; every entry at or
  // above it takes its upper neighbor when the order is deleted.
  assign first = match_r & (~match_r + {{(DEPTH-1){1'b0}}, 1'b1});
  assign shift = ~(first - {{(DEPTH-1){1'b0}}, 1'b1});
  assign hit   = |first;

  always_comb begin
    found_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_sel = found_sel | (first[i] ? data_r[i] : 64'd0);
    end
  end

  always_comb begin
    ids_nxt    = ids_r;
    data_nxt   = data_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    found_nxt  = '0;
    case (req_kind_r)
      KIND_ADD: begin
        if (req_price_r != level_price_r) begin
          status_nxt = ST_PRICE;
        end else if (count_r >= CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          ids_nxt[count_r[IDX_W-1:0]]  = req_id_r;
          data_nxt[count_r[IDX_W-1:0]] = req_data_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_POP, KIND_CANCEL, KIND_LOOKUP: begin
        if (!hit) begin
          status_nxt = ST_NONE;
        end else begin
          found_nxt = found_sel;
          if (req_kind_r != KIND_LOOKUP) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (shift[i]) begin
                ids_nxt[i]  = ids_r[i+1];
                data_nxt[i] = data_r[i+1];
              end
            end
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_price_r <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        level_price_r <= cfg_data;
      end
      if (cmd.exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r  <= kind_t'(in_kind);
      req_id_r    <= in_order_id;
      req_price_r <= in_order_price;
      req_data_r  <= in_order_data;
    end
    if (cmd.match) begin
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      ids_r       <= ids_nxt;
      data_r      <= data_nxt;
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      head_id_r   <= (count_nxt != '0) ? ids_nxt[0] : 32'd0;
      head_data_r <= (count_nxt != '0) ? data_nxt[0] : 64'd0;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_data  = found_r;
  assign out_head_id     = head_id_r;
  assign out_head_data   = head_data_r;
  assign out_order_count = 7'(count_r);
  assign out_is_empty    = (count_r == '0);

endmodule

// ===== rtl/core/ploq_chk.sv =====
// Port-level checker for the price level order queue, bound to the top level.
// Depends on ploq_pkg for the queue depth.
module ploq_chk import ploq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] head_id,
  input logic [63:0] head_data,
  input logic [6:0]  order_count,
  input logic        is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(order_count))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (order_count == 7'd0)))
    else $error("empty flag disagrees with order count");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> (head_id == 32'd0) && (head_data == 64'd0))
    else $error("empty queue reports a head order");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (order_count <= 7'(DEPTH)))
    else $error("order count exceeds queue depth");

endmodule

bind price_level_order_queue_unit ploq_chk u_ploq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .head_id     (out_ch.head_id),
  .head_data   (out_ch.head_data),
  .order_count (out_ch.order_count),
  .is_empty    (out_ch.is_empty)
);

// ===== dv/tb_price_level_order_queue_unit.sv =====
// Self-checking testbench for price_level_order_queue_unit: directed table, then random
// order flow in phases, each result word checked against an in-bench order book model or a pinned table value.
// Depends on ploq_pkg and the channel interfaces in ploq_if.
`timescale 1ns / 100ps

module tb_price_level_order_queue_unit;
  import ploq_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] found_data;
    logic [31:0] head_id;
    logic [63:0] head_data;
    logic [6:0]  order_count;
    logic        is_empty;
  } level_result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] data;
  } resting_order_t;

  typedef struct packed {
    kind_t         kind;
    logic [31:0]   id;
    logic [31:0]   price;
    logic [63:0]   data;
    logic          pinned;
    level_result_t want;
  } request_row_t;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} flow_mode_t;

  localparam level_result_t UNPINNED = '0;
  localparam level_result_t EMPTY_MISS = '{ST_NONE, 64'd0, 32'd0, 64'd0, 7'd0, 1'b1};
  localparam int DIR_ROWS = 20;
  localparam int PHASE_ITEMS = 100;

  localparam request_row_t DIR_TBL [0:DIR_ROWS-1] = '{
    '{KIND_POP, 32'd0, 32'd0, 64'd0, 1'b1, EMPTY_MISS},
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b1, EMPTY_MISS},
    '{KIND_CANCEL, 32'd0, 32'd0, 64'd0, 1'b1, EMPTY_MISS},
    '{KIND_ADD, 32'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_PRICE, 64'd0, 32'd0, 64'd0, 7'd0, 1'b1}},
    '{KIND_ADD, 32'hFFFF_FFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, 64'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1, 1'b0}},
    '{KIND_ADD, 32'd0, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_ADD, 32'hFFFF_FFFF, 32'd0, 64'h5555_5555_5555_5555, 1'b0, UNPINNED},
    '{KIND_ADD, 32'h8000_0000, 32'd0, 64'h8000_0000_0000_0001, 1'b0, UNPINNED},
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_CANCEL, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_CANCEL, 32'd0, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_LOOKUP, 32'd0, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_ADD, 32'd7, 32'd1, 64'h0123_4567_89AB_CDEF, 1'b0, UNPINNED},
    '{KIND_LOOKUP, 32'h8000_0000, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_POP, 32'd0, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_POP, 32'd0, 32'd0, 64'd0, 1'b0, UNPINNED},
    '{KIND_POP, 32'd0, 32'd0, 64'd0, 1'b1, EMPTY_MISS},
    '{KIND_ADD, 32'hAAAA_5555, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, UNPINNED},
    '{KIND_CANCEL, 32'hAAAA_5555, 32'd0, 64'd0, 1'b0, UNPINNED}
  };

  logic clk;
  logic rst_n;

  ploq_in_if  in_ch ();
  ploq_out_if out_ch ();
  ploq_cfg_if cfg_ch ();

  price_level_order_queue_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  resting_order_t resting[$];
  logic [31:0]    book_price;
  level_result_t  pending_results[$];
  int             fault_count;
  int             hold_off_len;
  bit             src_idle;
  bit             sink_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic level_result_t apply_request(kind_t k, logic [31:0] id,
                                                  logic [31:0] price, logic [63:0] data);
    level_result_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    if (k == KIND_CANCEL || k == KIND_LOOKUP) begin
      for (int i = 0; i < resting.size(); i++) begin
        if (pos < 0 && resting[i].id == id) pos = i;
      end
    end
    case (k)
      KIND_ADD: begin
        if (price != book_price) r.status = ST_PRICE;
        else if (resting.size() >= DEPTH) r.status = ST_FULL;
        else resting.insert(resting.size(), resting_order_t'{id, data});
      end
      KIND_POP: begin
        if (resting.size() == 0) begin
          r.status = ST_NONE;
        end else begin
          r.found_data = resting[0].data;
          resting.delete(0);
        end
      end
      default: begin
        if (pos < 0) begin
          r.status = ST_NONE;
        end else begin
          r.found_data = resting[pos].data;
          if (k == KIND_CANCEL) resting.delete(pos);
        end
      end
    endcase
    if (resting.size() != 0) begin
      r.head_id = resting[0].id;
      r.head_data = resting[0].data;
    end
    r.order_count = 7'(resting.size());
    r.is_empty = (resting.size() == 0);
    return r;
  endfunction

  function automatic logic [31:0] pick_order_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5 && resting.size() != 0) return resting[$urandom_range(0, resting.size() - 1)].id;
    if (r < 8) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  task automatic send_request(input kind_t k, input logic [31:0] id, input logic [31:0] price,
                              input logic [63:0] data, input bit pinned,
                              input level_result_t want);
    level_result_t predicted;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.order_id    <= id;
    in_ch.order_price <= price;
    in_ch.order_data  <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_request(k, id, price, data);
    pending_results.insert(pending_results.size(), pinned ? want : predicted);
  endtask

  task automatic drain_and_set_price(input logic [31:0] price);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= price;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    book_price = price;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    level_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 64'd0, {62'd0, out_ch.status});
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_ch.status));
        if (out_ch.found_data !== want.found_data)
          report_mismatch("found_data", want.found_data, out_ch.found_data);
        if (out_ch.head_id !== want.head_id)
          report_mismatch("head_id", 64'(want.head_id), 64'(out_ch.head_id));
        if (out_ch.head_data !== want.head_data)
          report_mismatch("head_data", want.head_data, out_ch.head_data);
        if (out_ch.order_count !== want.order_count)
          report_mismatch("order_count", 64'(want.order_count), 64'(out_ch.order_count));
        if (out_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", 64'(want.is_empty), 64'(out_ch.is_empty));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] phase_price [0:3];
    flow_mode_t  mode;
    int          mode_left;
    kind_t       k;
    logic [31:0] price;
    fault_count  = 0;
    hold_off_len = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    book_price   = '0;
    mode         = MODE_FILL;
    mode_left    = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_ADD;
    in_ch.order_id     <= '0;
    in_ch.order_price  <= '0;
    in_ch.order_data   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(DIR_TBL[i].kind, DIR_TBL[i].id, DIR_TBL[i].price, DIR_TBL[i].data,
                   DIR_TBL[i].pinned, DIR_TBL[i].want);

    phase_price[0] = 32'hFFFF_FFFF;
    phase_price[1] = $urandom;
    phase_price[2] = 32'h0000_0000;
    phase_price[3] = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set_price(phase_price[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 20) hold_off_len = 300;
        if (ph == 3) begin
          src_idle  = 1'b0;
          sink_idle = 1'b0;
        end else if ($urandom_range(0, 31) == 0) begin
          src_idle  = 1'($urandom_range(0, 1));
          sink_idle = 1'($urandom_range(0, 1));
        end
        case (mode)
          MODE_FILL: begin
            k = ($urandom_range(0, 99) < 85) ? KIND_ADD : kind_t'($urandom_range(1, 3));
            if (resting.size() == DEPTH) mode_left++;
            if (mode_left > 5) begin
              mode = MODE_MIX;
              mode_left = $urandom_range(10, 40);
            end
          end
          MODE_MIX: begin
            k = kind_t'($urandom_range(0, 3));
            mode_left--;
            if (mode_left <= 0) mode = MODE_DRAIN;
          end
          default: begin
            k = ($urandom_range(0, 99) < 20) ? KIND_ADD : kind_t'($urandom_range(1, 3));
            if (resting.size() == 0) begin
              mode = MODE_FILL;
              mode_left = 0;
            end
          end
        endcase
        if ($urandom_range(0, 99) < 85) price = book_price;
        else if ($urandom_range(0, 1) == 0) price = $urandom;
        else price = book_price ^ (32'd1 << $urandom_range(0, 31));
        send_request(k, pick_order_id(), price, {$urandom, $urandom}, 1'b0, UNPINNED);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
